// ===== hdl/bounded_queue_stack_list_engine_assert.svh =====
// ----------------------------------------------------------------------------
// bounded queue, stack and list engine: assertion macros
// shared concurrent assertion forms used by the engine rtl
// ----------------------------------------------------------------------------
`ifndef BOUNDED_QUEUE_STACK_LIST_ENGINE_ASSERT_SVH
`define BOUNDED_QUEUE_STACK_LIST_ENGINE_ASSERT_SVH

// condition holds at every clock edge out of reset
`define BQSL_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error("bqsl assertion failed");

// consequence holds in the same cycle as the antecedent
`define BQSL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bqsl assertion failed");

// consequence holds in the cycle after the antecedent
`define BQSL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bqsl assertion failed");

`endif

// ===== hdl/bqsl_pkg.sv =====
// ----------------------------------------------------------------------------
// bqsl_pkg
// field widths, operation, container and status codes of the engine
// ----------------------------------------------------------------------------
package bqsl_pkg;

    localparam int DEF_CAPACITY = 10;

    localparam int KIND_W   = 3;
    localparam int CONT_W   = 2;
    localparam int VALUE_W  = 32;
    localparam int ROOM_W   = 16;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 4;

    typedef logic [STATUS_W-1:0] t_status;

    // operation codes
    localparam logic [KIND_W-1:0] KIND_INSERT       = 3'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE_FIRST = 3'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE_VALUE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR        = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READ         = 3'd4;

    // container codes
    localparam logic [CONT_W-1:0] CONT_QUEUE   = 2'd0;
    localparam logic [CONT_W-1:0] CONT_STACK   = 2'd1;
    localparam logic [CONT_W-1:0] CONT_LIST    = 2'd2;
    localparam logic [CONT_W-1:0] CONT_INVALID = 2'd3;

    // status codes
    localparam t_status ST_OK          = 3'd0;
    localparam t_status ST_INVALID     = 3'd1;
    localparam t_status ST_FULL        = 3'd2;
    localparam t_status ST_EMPTY       = 3'd3;
    localparam t_status ST_NOT_FOUND   = 3'd4;
    localparam t_status ST_UNSUPPORTED = 3'd5;
    localparam t_status ST_TOO_SMALL   = 3'd6;

endpackage

// ===== hdl/bounded_queue_stack_list_engine.sv =====
// ----------------------------------------------------------------------------
// bounded_queue_stack_list_engine
// command engine over a bounded queue, stack and list of signed 32-bit words
// ----------------------------------------------------------------------------
// A command is taken at a rising edge with start high and busy low; busy then
// stays high until the command's last result has been driven. Results appear
// on o_strobe for exactly one cycle each and cannot be stalled, so the
// receiver must take every strobe. A run of results (read) comes out on
// back-to-back cycles with o_last on the final one. Insert, clear, invalid and
// the other single-step error cases answer straight from the decode state;
// remove-first fetches the front word and answers when it arrives; read gives
// a size header and then the n stored words; remove-value on the list compares
// the entries in turn and, on a hit, moves each entry behind the removed one
// down a slot; a miss answers not found after the last compare.
// All of it runs through a single-port-read, single-port-write entry
// memory with a registered read, walked by one position counter under a
// small sequencer; that one read per cycle sets the read and search rate.
// The queue and stack live in circular slots with a per-store head pointer,
// so stack push and pops need no data movement.
// ----------------------------------------------------------------------------
`include "bounded_queue_stack_list_engine_assert.svh"

module bounded_queue_stack_list_engine #(
    parameter int CAPACITY = bqsl_pkg::DEF_CAPACITY
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [bqsl_pkg::KIND_W-1:0]          i_kind,
    input  logic [bqsl_pkg::CONT_W-1:0]          i_container,
    input  logic signed [bqsl_pkg::VALUE_W-1:0]  i_value,
    input  logic [bqsl_pkg::ROOM_W-1:0]          i_buffer_room,
    input  logic                                 i_count_only,
    output logic                                 o_strobe,
    output logic [bqsl_pkg::STATUS_W-1:0]        o_status,
    output logic signed [bqsl_pkg::VALUE_W-1:0]  o_result_value,
    output logic [bqsl_pkg::COUNT_W-1:0]         o_entry_count,
    output logic                                 o_last
);

    // size, head and position width; slot and word address width
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int AW    = $clog2(3 * CAPACITY);
    localparam int DEPTH = 3 * CAPACITY;
    localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
    localparam logic [CW:0]   CAP_W  = (CW+1)'(CAPACITY);

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;  // waiting for a command
    localparam logic [2:0] S_EXEC  = 3'd1;  // decode, and the ops that end here
    localparam logic [2:0] S_POP   = 3'd2;  // front word arrives from memory
    localparam logic [2:0] S_SCMP  = 3'd3;  // list search, one compare a cycle
    localparam logic [2:0] S_MOVE  = 3'd4;  // close the gap after a removal
    localparam logic [2:0] S_RDOUT = 3'd5;  // stream the stored words

    // ---- state ----
    logic [2:0]                          r_state, n_state;
    logic [CW-1:0]                       r_size [3];
    logic [CW-1:0]                       n_size [3];
    logic [CW-1:0]                       r_head [3];
    logic [CW-1:0]                       n_head [3];
    logic [CW-1:0]                       r_idx, n_idx;

    // latched command fields
    logic [bqsl_pkg::KIND_W-1:0]         r_kind;
    logic [bqsl_pkg::CONT_W-1:0]         r_cont;
    logic [bqsl_pkg::VALUE_W-1:0]        r_value;
    logic [bqsl_pkg::ROOM_W-1:0]         r_room;
    logic                                r_count_only;

    // entry memory, one region of CAPACITY slots per store
    logic [bqsl_pkg::VALUE_W-1:0]        r_mem [DEPTH];
    logic [bqsl_pkg::VALUE_W-1:0]        r_rd_data;
    logic                                rd_en;
    logic [CW-1:0]                       rd_pos;
    logic                                wr_en;
    logic [CW-1:0]                       wr_slot;
    logic [bqsl_pkg::VALUE_W-1:0]        wr_data;
    logic [AW-1:0]                       rd_addr, wr_addr;

    // result register
    logic                                r_strobe, n_strobe;
    bqsl_pkg::t_status                   r_status, n_status;
    logic [bqsl_pkg::VALUE_W-1:0]        r_rval, n_rval;
    logic [bqsl_pkg::COUNT_W-1:0]        r_count, n_count;
    logic                                r_last, n_last;

    // selected store
    logic [CW-1:0]                       cur_n, cur_h, dec_h;
    logic [AW-1:0]                       cur_base;
    logic [CW:0]                         idx_p1, idx_p2;
    logic                                accept;

    // start of a store's region
    function automatic logic [AW-1:0] f_base(input logic [bqsl_pkg::CONT_W-1:0] c);
        logic [AW-1:0] b;
        unique case (c)
            bqsl_pkg::CONT_QUEUE: b = '0;
            bqsl_pkg::CONT_STACK: b = AW'(CAPACITY);
            bqsl_pkg::CONT_LIST:  b = AW'(2 * CAPACITY);
            default:              b = '0;
        endcase
        return b;
    endfunction

    // head plus offset, folded back into 0 .. CAPACITY-1
    function automatic logic [CW-1:0] f_slot(input logic [CW-1:0] h,
                                             input logic [CW-1:0] p);
        logic [CW:0] s;
        s = {1'b0, h} + {1'b0, p};
        if (s >= CAP_W) begin
            s = s - CAP_W;
        end
        return CW'(s);
    endfunction

    assign accept = start && (r_state == S_IDLE);
    assign busy   = (r_state != S_IDLE);

    always_comb begin
        unique case (r_cont)
            bqsl_pkg::CONT_QUEUE: begin cur_n = r_size[0]; cur_h = r_head[0]; end
            bqsl_pkg::CONT_STACK: begin cur_n = r_size[1]; cur_h = r_head[1]; end
            bqsl_pkg::CONT_LIST:  begin cur_n = r_size[2]; cur_h = r_head[2]; end
            default:              begin cur_n = '0;        cur_h = '0;        end
        endcase
    end

    assign cur_base = f_base(r_cont);
    assign dec_h    = (cur_h == '0) ? (CAP_C - CW'(1)) : (cur_h - CW'(1));
    assign idx_p1   = {1'b0, r_idx} + (CW+1)'(1);
    assign idx_p2   = {1'b0, r_idx} + (CW+1)'(2);
    assign rd_addr  = cur_base + AW'(f_slot(cur_h, rd_pos));
    assign wr_addr  = cur_base + AW'(wr_slot);

    // ---- sequencer ----
    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_size   = r_size;
        n_head   = r_head;
        n_strobe = 1'b0;
        n_status = bqsl_pkg::ST_OK;
        n_rval   = '0;
        n_count  = '0;
        n_last   = 1'b1;
        rd_en    = 1'b0;
        rd_pos   = '0;
        wr_en    = 1'b0;
        wr_slot  = '0;
        wr_data  = r_value;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                n_state = S_IDLE;
                if (r_kind > bqsl_pkg::KIND_READ || r_cont == bqsl_pkg::CONT_INVALID) begin
                    n_strobe = 1'b1;
                    n_status = bqsl_pkg::ST_INVALID;
                end else begin
                    unique case (r_kind)
                        bqsl_pkg::KIND_INSERT: begin
                            n_strobe = 1'b1;
                            if (cur_n >= CAP_C) begin
                                n_status = bqsl_pkg::ST_FULL;
                            end else begin
                                wr_en = 1'b1;
                                // stack grows at the front, the others at the tail
                                if (r_cont == bqsl_pkg::CONT_STACK) begin
                                    wr_slot        = dec_h;
                                    n_head[r_cont] = dec_h;
                                end else begin
                                    wr_slot = f_slot(cur_h, cur_n);
                                end
                                n_size[r_cont] = cur_n + CW'(1);
                            end
                        end
                        bqsl_pkg::KIND_REMOVE_FIRST: begin
                            if (cur_n == '0) begin
                                n_strobe = 1'b1;
                                n_status = bqsl_pkg::ST_EMPTY;
                            end else begin
                                // fetch the front, retire it by moving the head
                                rd_en          = 1'b1;
                                n_head[r_cont] = f_slot(cur_h, CW'(1));
                                n_size[r_cont] = cur_n - CW'(1);
                                n_state        = S_POP;
                            end
                        end
                        bqsl_pkg::KIND_REMOVE_VALUE: begin
                            if (r_cont != bqsl_pkg::CONT_LIST) begin
                                n_strobe = 1'b1;
                                n_status = bqsl_pkg::ST_UNSUPPORTED;
                            end else if (cur_n == '0) begin
                                n_strobe = 1'b1;
                                n_status = bqsl_pkg::ST_EMPTY;
                            end else begin
                                rd_en   = 1'b1;
                                n_idx   = '0;
                                n_state = S_SCMP;
                            end
                        end
                        bqsl_pkg::KIND_CLEAR: begin
                            n_strobe = 1'b1;
                            if (cur_n == '0) begin
                                n_status = bqsl_pkg::ST_EMPTY;
                            end else begin
                                n_count        = bqsl_pkg::COUNT_W'(cur_n);
                                n_size[r_cont] = '0;
                            end
                        end
                        default: begin
                            // read
                            n_strobe = 1'b1;
                            if (r_count_only) begin
                                if (r_room != '0) begin
                                    n_status = bqsl_pkg::ST_INVALID;
                                end else begin
                                    n_count = bqsl_pkg::COUNT_W'(cur_n);
                                end
                            end else if (r_room < bqsl_pkg::ROOM_W'(cur_n)) begin
                                n_status = bqsl_pkg::ST_TOO_SMALL;
                                n_count  = bqsl_pkg::COUNT_W'(cur_n);
                            end else begin
                                // size header, then the words front to back
                                n_count = bqsl_pkg::COUNT_W'(cur_n);
                                n_last  = (cur_n == '0);
                                if (cur_n != '0) begin
                                    rd_en   = 1'b1;
                                    n_idx   = '0;
                                    n_state = S_RDOUT;
                                end
                            end
                        end
                    endcase
                end
            end

            S_POP: begin
                n_strobe = 1'b1;
                n_rval   = r_rd_data;
                n_state  = S_IDLE;
            end

            S_SCMP: begin
                // r_rd_data holds the list word at r_idx
                if (r_rd_data == r_value) begin
                    if (idx_p1 == {1'b0, cur_n}) begin
                        n_strobe       = 1'b1;
                        n_size[r_cont] = cur_n - CW'(1);
                        n_state        = S_IDLE;
                    end else begin
                        rd_en   = 1'b1;
                        rd_pos  = CW'(idx_p1);
                        n_state = S_MOVE;
                    end
                end else if (idx_p1 == {1'b0, cur_n}) begin
                    n_strobe = 1'b1;
                    n_status = bqsl_pkg::ST_NOT_FOUND;
                    n_state  = S_IDLE;
                end else begin
                    rd_en  = 1'b1;
                    rd_pos = CW'(idx_p1);
                    n_idx  = CW'(idx_p1);
                end
            end

            S_MOVE: begin
                // r_rd_data holds the word at r_idx + 1, shift it down one slot
                wr_en   = 1'b1;
                wr_slot = f_slot(cur_h, r_idx);
                wr_data = r_rd_data;
                if (idx_p2 == {1'b0, cur_n}) begin
                    n_strobe       = 1'b1;
                    n_size[r_cont] = cur_n - CW'(1);
                    n_state        = S_IDLE;
                end else begin
                    rd_en  = 1'b1;
                    rd_pos = CW'(idx_p2);
                    n_idx  = CW'(idx_p1);
                end
            end

            S_RDOUT: begin
                n_strobe = 1'b1;
                n_rval   = r_rd_data;
                n_count  = bqsl_pkg::COUNT_W'(cur_n);
                n_last   = (idx_p1 == {1'b0, cur_n});
                if (idx_p1 == {1'b0, cur_n}) begin
                    n_state = S_IDLE;
                end else begin
                    rd_en  = 1'b1;
                    rd_pos = CW'(idx_p1);
                    n_idx  = CW'(idx_p1);
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ---- control registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_idx    <= '0;
            r_size   <= '{default: '0};
            r_head   <= '{default: '0};
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_size   <= n_size;
            r_head   <= n_head;
            r_strobe <= n_strobe;
        end
    end

    // ---- payload registers ----
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind       <= i_kind;
            r_cont       <= i_container;
            r_value      <= i_value;
            r_room       <= i_buffer_room;
            r_count_only <= i_count_only;
        end
        r_status <= n_status;
        r_rval   <= n_rval;
        r_count  <= n_count;
        r_last   <= n_last;
    end

    // ---- entry memory ----
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign o_strobe       = r_strobe;
    assign o_status       = r_status;
    assign o_result_value = r_rval;
    assign o_entry_count  = r_count;
    assign o_last         = r_last;

    // ---- assertions ----
    `BQSL_ASSERT_ALWAYS(a_size_bound, i_clk, i_rst_n, (r_size[0] <= CAP_C) && (r_size[1] <= CAP_C) && (r_size[2] <= CAP_C))
    `BQSL_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    `BQSL_ASSERT_NEXT(a_last_gap, i_clk, i_rst_n, o_strobe && o_last, !o_strobe)
    `BQSL_ASSERT_NEXT(a_run_continues, i_clk, i_rst_n, o_strobe && !o_last, o_strobe)
    `BQSL_ASSERT_SAME(a_error_single, i_clk, i_rst_n, o_strobe && (o_status != bqsl_pkg::ST_OK), o_last)

endmodule
